### rtl/tlfig_pkg.sv
// ----------------------------------------------------------------------------
// tlfig_pkg
// Shared types and constants of the terrain fan index generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tlfig_pkg;

  localparam int unsigned VIDX_W    = 32;  // vertex index width
  localparam int unsigned NUM_SIDES = 4;   // left, top, right, bottom
  localparam int unsigned SIDE_W    = 2;
  localparam int unsigned ROW_W     = 16;  // row_width register
  localparam int unsigned PSIZE_W   = 9;   // patch_size register
  localparam int unsigned COORD_W   = 9;
  localparam int unsigned CORE_W    = 3;
  localparam int unsigned NBR_W     = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QPTR_W    = 1;
  localparam int unsigned QCNT_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATCH_SIZE = 1'd1;

  localparam logic [ROW_W-1:0]   ROW_WIDTH_RST  = 16'd257;
  localparam logic [PSIZE_W-1:0] PATCH_SIZE_RST = 9'd33;

  localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 2'd3;

  // One classified fan: center index, first rim vertex, signed rim step of
  // each side (left, top, right, bottom) and whether that side is split.
  typedef struct packed {
    logic [VIDX_W-1:0]                   ctr;
    logic [VIDX_W-1:0]                   p0;
    logic [NUM_SIDES-1:0][VIDX_W-1:0]    delta;
    logic [NUM_SIDES-1:0]                dbl;
  } fan_job_t;

endpackage

`default_nettype wire

### rtl/tlfig_front.sv
// ----------------------------------------------------------------------------
// tlfig_front
// Accepts fan items, holds the configuration and classifies each fan into
// a job: edge levels, center index, start vertex and per-side rim steps.
// ----------------------------------------------------------------------------
`default_nettype none

module tlfig_front
  import tlfig_pkg::*;
#(
  parameter int unsigned MAX_LEVEL = 7
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  wire logic [ROW_W-1:0]     cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [COORD_W-1:0]   fan_x_i,
  input  wire logic [COORD_W-1:0]   fan_z_i,
  input  wire logic [CORE_W-1:0]    core_level_i,
  input  wire logic [NBR_W-1:0]     left_level_i,
  input  wire logic [NBR_W-1:0]     right_level_i,
  input  wire logic [NBR_W-1:0]     top_level_i,
  input  wire logic [NBR_W-1:0]     bottom_level_i,
  output logic                      push_o,
  input  wire logic                 push_ready_i,
  output fan_job_t                  job_o
);

  localparam int unsigned LW     = $clog2(MAX_LEVEL + 2);
  localparam int unsigned PROD_W = COORD_W + ROW_W;
  localparam int unsigned END_W  = PSIZE_W + 2;

  logic [ROW_W-1:0]   row_width_q;
  logic [PSIZE_W-1:0] patch_size_q;

  logic               a_valid_q, a_valid_d;
  logic [COORD_W-1:0] x_q, z_q;
  logic [LW-1:0]      core_q, nl_q, nr_q, nt_q, nb_q;
  logic [PROD_W-1:0]  prod_q;

  logic [LW-1:0]      core_sat, nl_sat, nr_sat, nt_sat, nb_sat;
  logic               in_acc;

  logic [END_W-1:0]   fan_step, end_pos;
  logic [LW-1:0]      ll, lr, lt, lb;
  logic [VIDX_W-1:0]  w32, p0;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q  <= ROW_WIDTH_RST;
      patch_size_q <= PATCH_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_ROW_WIDTH:  row_width_q  <= cfg_wdata_i;
        CFG_PATCH_SIZE: patch_size_q <= cfg_wdata_i[PSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp levels to the supported range
  always_comb begin
    core_sat = (core_level_i > MAX_LEVEL) ? LW'(MAX_LEVEL) : LW'(core_level_i);
    nl_sat = (left_level_i > MAX_LEVEL + 1) ? LW'(MAX_LEVEL + 1) : LW'(left_level_i);
    nr_sat = (right_level_i > MAX_LEVEL + 1) ? LW'(MAX_LEVEL + 1) : LW'(right_level_i);
    nt_sat = (top_level_i > MAX_LEVEL + 1) ? LW'(MAX_LEVEL + 1) : LW'(top_level_i);
    nb_sat = (bottom_level_i > MAX_LEVEL + 1) ? LW'(MAX_LEVEL + 1) : LW'(bottom_level_i);
  end

  assign in_ready_o = !a_valid_q || push_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    a_valid_d = a_valid_q;
    if (in_acc) begin
      a_valid_d = 1'b1;
    end else if (push_ready_i) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  // capture the item and the row product
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q    <= fan_x_i;
      z_q    <= fan_z_i;
      core_q <= core_sat;
      nl_q   <= nl_sat;
      nr_q   <= nr_sat;
      nt_q   <= nt_sat;
      nb_q   <= nb_sat;
      prod_q <= PROD_W'(fan_z_i) * PROD_W'(row_width_q);
    end
  end

  // edge classification; a negative end position never matches
  always_comb begin
    fan_step = END_W'(2) << core_q;
    end_pos  = END_W'(patch_size_q) - END_W'(1) - fan_step;
    ll = (x_q == '0) ? nl_q : core_q;
    lb = (z_q == '0) ? nb_q : core_q;
    lr = (END_W'(x_q) == end_pos) ? nr_q : core_q;
    lt = (END_W'(z_q) == end_pos) ? nt_q : core_q;
    w32 = VIDX_W'(row_width_q);
    p0  = VIDX_W'(prod_q) + VIDX_W'(x_q);

    job_o.p0       = p0;
    job_o.ctr      = p0 + (w32 << core_q) + (VIDX_W'(1) << core_q);
    job_o.delta[0] = w32 << ll;
    job_o.delta[1] = VIDX_W'(1) << lt;
    job_o.delta[2] = VIDX_W'(0) - (w32 << lr);
    job_o.delta[3] = VIDX_W'(0) - (VIDX_W'(1) << lb);
    job_o.dbl[0]   = (ll == core_q);
    job_o.dbl[1]   = (lt == core_q);
    job_o.dbl[2]   = (lr == core_q);
    job_o.dbl[3]   = (lb == core_q);
  end

  assign push_o = a_valid_q;

endmodule

`default_nettype wire

### rtl/tlfig_queue.sv
// ----------------------------------------------------------------------------
// tlfig_queue
// Two-entry job queue between the classifier and the triangle sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module tlfig_queue
  import tlfig_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  output logic      push_ready_o,
  input  fan_job_t  push_job_i,
  output logic      head_valid_o,
  input  wire logic pop_i,
  output fan_job_t  head_job_o
);

  fan_job_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q, count_d;
  logic                do_push, do_pop;

  assign push_ready_o = (count_q != QCNT_W'(QDEPTH));
  assign head_valid_o = (count_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;
  assign head_job_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

### rtl/tlfig_back.sv
// ----------------------------------------------------------------------------
// tlfig_back
// Walks the fan rim of the head job and emits one triangle per cycle into
// the output register while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module tlfig_back
  import tlfig_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              head_valid_i,
  input  fan_job_t               head_job_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [VIDX_W-1:0]      vertex_a_o,
  output logic [VIDX_W-1:0]      vertex_b_o,
  output logic [VIDX_W-1:0]      vertex_c_o,
  output logic                   last_o
);

  logic [SIDE_W-1:0] side_q;
  logic              sub_q;
  logic [VIDX_W-1:0] cur_q;
  logic              out_valid_q;
  logic [VIDX_W-1:0] va_q, vb_q, vc_q;
  logic              last_q;

  logic              advance, first, is_last, split;
  logic [VIDX_W-1:0] b_v, c_v;

  always_comb begin
    first   = (side_q == '0) && !sub_q;
    b_v     = first ? head_job_i.p0 : cur_q;
    c_v     = b_v + head_job_i.delta[side_q];
    split   = head_job_i.dbl[side_q] && !sub_q;
    is_last = (side_q == SIDE_BOTTOM) && !split;
    advance = head_valid_i && (!out_valid_q || out_ready_i);
  end

  assign pop_o = advance && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q      <= '0;
      sub_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        if (split) begin
          sub_q <= 1'b1;
        end else begin
          sub_q  <= 1'b0;
          side_q <= side_q + SIDE_W'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      cur_q  <= c_v;
      va_q   <= head_job_i.ctr;
      vb_q   <= b_v;
      vc_q   <= c_v;
      last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign vertex_a_o  = va_q;
  assign vertex_b_o  = vb_q;
  assign vertex_c_o  = vc_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

### rtl/terrain_lod_fan_index_gen.sv
// ----------------------------------------------------------------------------
// terrain_lod_fan_index_gen
// Geomipmapping triangle fan index generator: one fan cell in, four to
// eight triangles of vertex indices out.
// ----------------------------------------------------------------------------
// Path: an accepted fan is registered in the classifier, then in the queue,
//   and its triangles are registered at the output by the rim sequencer.
// Throughput: one triangle per cycle while the output is not stalled. A
//   two-job queue lets fans enter while earlier ones are still being emitted.
// Reset: asynchronous, active low; clears control state, row_width to 257
//   and patch_size to 33.
`default_nettype none

module terrain_lod_fan_index_gen
  import tlfig_pkg::*;
#(
  parameter int unsigned MAX_LEVEL = 7
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  wire logic [ROW_W-1:0]     cfg_wdata_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // fan_x[8:0], fan_z[17:9], core_level[20:18], left_level[24:21],
  // right_level[28:25], top_level[32:29], bottom_level[36:33], zero fill
  input  wire logic [39:0]          s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // vertex_a[31:0], vertex_b[63:32], vertex_c[95:64]
  output logic [95:0]               m_axis_tdata,
  output logic                      m_axis_tlast
);

  logic     push, push_ready, head_valid, pop;
  fan_job_t push_job, head_job;

  tlfig_front #(
    .MAX_LEVEL(MAX_LEVEL)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .fan_x_i        (s_axis_tdata[8:0]),
    .fan_z_i        (s_axis_tdata[17:9]),
    .core_level_i   (s_axis_tdata[20:18]),
    .left_level_i   (s_axis_tdata[24:21]),
    .right_level_i  (s_axis_tdata[28:25]),
    .top_level_i    (s_axis_tdata[32:29]),
    .bottom_level_i (s_axis_tdata[36:33]),
    .push_o         (push),
    .push_ready_i   (push_ready),
    .job_o          (push_job)
  );

  tlfig_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_job_o   (head_job)
  );

  tlfig_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .vertex_a_o   (m_axis_tdata[31:0]),
    .vertex_b_o   (m_axis_tdata[63:32]),
    .vertex_c_o   (m_axis_tdata[95:64]),
    .last_o       (m_axis_tlast)
  );

endmodule

`default_nettype wire
